// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the decimal text converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

// ===== rtl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal text converter package
// Constants, the pipeline word type and the double-dabble step function.
// ----------------------------------------------------------------------------
package sida_pkg;

   // Widths of the binary magnitude and of the packed BCD digits.
   localparam int MagWidth         = 32;
   localparam int NumDigits        = 10;
   localparam int BcdWidth         = 4 * NumDigits;
   localparam int DigitIndexWidth  = 4;
   localparam int CharWidth        = 6;

   // The 32 shift steps are split evenly over the conversion stages.
   localparam int NumDabbleStages  = 4;
   localparam int StepsPerStage    = MagWidth / NumDabbleStages;

   // Character codes.
   localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
   localparam logic [CharWidth-1:0] AsciiMinus = 6'd45;

   // Word that travels down the conversion pipeline.
   typedef struct packed {
      logic                negative;
      logic [BcdWidth-1:0] bcd;
      logic [MagWidth-1:0] bin;
   } sida_work_type;

   typedef logic [DigitIndexWidth-1:0] sida_index_type;

   // Runs one stage worth of double-dabble steps: each BCD digit of five
   // or more is raised by three, then the whole word shifts left by one.
   function automatic sida_work_type dabble_steps(input sida_work_type w);
      sida_work_type r;
      logic [3:0]    d;
      r = w;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int k = 0; k < NumDigits; k++) begin
            d = r.bcd[k*4 +: 4];
            if (d >= 4'd5) begin
               r.bcd[k*4 +: 4] = d + 4'd3;
            end
         end
         {r.bcd, r.bin} = {r.bcd[BcdWidth-2:0], r.bin, 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/sida_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// Double-dabble pipeline stage
// One register stage of the binary to BCD conversion, with stall handling.
// ----------------------------------------------------------------------------
module sida_dabble_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sida_pkg::sida_work_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output sida_pkg::sida_work_type out_data,
   input  logic                   out_ready
);
   import sida_pkg::*;

   logic          valid_ff;
   sida_work_type data_ff;
   sida_work_type data_in;

   // The stage takes a new word when it is empty or its word moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Conversion steps for this stage.
   always_comb begin
      data_in = dabble_steps(in_data);
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Payload register, held while the stage is stalled.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/sida_serializer.sv =====
// ----------------------------------------------------------------------------
// Character serialiser
// Sends the sign and the significant digits of one number, one per cycle.
// ----------------------------------------------------------------------------
module sida_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  sida_pkg::sida_work_type        in_data,
   output logic                          in_ready,
   output logic                          rsp_strobe,
   output logic [sida_pkg::CharWidth-1:0] rsp_character,
   output logic                          rsp_last
);
   import sida_pkg::*;

   logic                 active_ff,  active_in;
   logic                 sign_ff,    sign_in;
   logic [BcdWidth-1:0]  digits_ff,  digits_in;
   sida_index_type       index_ff,   index_in;
   logic                 strobe_ff,  strobe_in;
   logic [CharWidth-1:0] char_ff,    char_in;
   logic                 last_ff,    last_in;
   logic                 final_char;
   logic [3:0]           digit;

   // Position of the most significant non-zero digit; zero for value zero.
   function automatic sida_index_type top_digit(input logic [BcdWidth-1:0] bcd);
      sida_index_type t;
      t = '0;
      for (int k = 0; k < NumDigits; k++) begin
         if (bcd[k*4 +: 4] != 4'd0) begin
            t = DigitIndexWidth'(k);
         end
      end
      return t;
   endfunction

   assign final_char = !sign_ff && (index_ff == '0);
   assign in_ready   = !active_ff || final_char;
   assign digit      = digits_ff[{index_ff, 2'b00} +: 4];

   // Character selection and the walk from the top digit down.
   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      digits_in = digits_ff;
      index_in  = index_ff;
      strobe_in = active_ff;
      char_in   = sign_ff ? AsciiMinus : (AsciiZero + {2'b00, digit});
      last_in   = final_char;
      if (active_ff) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (index_ff == '0) begin
            active_in = 1'b0;
         end else begin
            index_in = index_ff - 1'b1;
         end
      end
      if (in_ready && in_valid) begin
         active_in = 1'b1;
         sign_in   = in_data.negative;
         digits_in = in_data.bcd;
         index_in  = top_digit(in_data.bcd);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sign_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      index_ff  <= index_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal text
// Converts a signed 32-bit integer to its decimal ASCII characters.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Its text leaves on
// rsp_character one character per cycle, each marked by rsp_strobe for a
// single cycle, with rsp_last on the final one; the receiver must take every
// character as it appears. A negative number begins with a minus sign, and
// there are no leading zeros, so a number gives 1 to 11 characters. A number
// passes through the input register that forms the magnitude, four double-dabble
// stages of eight shift steps each, the serialiser's state registers and its
// output register. The serialiser sends the characters of a number one after
// another and can take the next number while it sends the final character of the
// last one. The conversion stages keep accepting numbers while the serialiser
// works, and busy rises only once they are all full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_strobe,
   output logic [sida_pkg::CharWidth-1:0] rsp_character,
   output logic                          rsp_last
);
   import sida_pkg::*;

   logic                 front_valid_ff;
   sida_work_type        front_data_ff;
   sida_work_type        front_data_in;
   logic                 front_ready;
   logic [MagWidth-1:0]  raw;

   logic                 stage_valid [NumDabbleStages+1];
   sida_work_type        stage_data  [NumDabbleStages+1];
   logic                 stage_ready [NumDabbleStages+1];

   // Sign and magnitude; the magnitude of the most negative value fits
   // because it is kept unsigned.
   always_comb begin
      raw                    = req_value;
      front_data_in.negative = raw[MagWidth-1];
      front_data_in.bcd      = '0;
      front_data_in.bin      = raw[MagWidth-1] ? (~raw + 1'b1) : raw;
   end

   assign front_ready = !front_valid_ff || stage_ready[0];
   assign busy        = !front_ready;

   // Input stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= start;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (front_ready && start) begin
         front_data_ff <= front_data_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_data_ff;

   // Binary to BCD conversion stages.
   for (genvar g = 0; g < NumDabbleStages; g++) begin : g_dabble
      sida_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_data   (stage_data[g]),
         .in_ready  (stage_ready[g]),
         .out_valid (stage_valid[g+1]),
         .out_data  (stage_data[g+1]),
         .out_ready (stage_ready[g+1])
      );
   end

   // Character output.
   sida_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stage_valid[NumDabbleStages]),
      .in_data       (stage_data[NumDabbleStages]),
      .in_ready      (stage_ready[NumDabbleStages]),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== rtl/sida_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal text converter checker
// Port-level assertions on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sida_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_strobe,
   input  logic [sida_pkg::CharWidth-1:0] rsp_character,
   input  logic                          rsp_last
);
   import sida_pkg::*;

   logic is_minus;
   logic is_digit;
   logic is_zero;

   assign is_minus = (rsp_character == AsciiMinus);
   assign is_zero  = (rsp_character == AsciiZero);
   assign is_digit = (rsp_character >= AsciiZero) && (rsp_character <= (AsciiZero + 6'd9));

   // Every character is a minus sign or a decimal digit.
   `SIDA_ASSERT_SAME(a_char_code, clock, reset, rsp_strobe, is_minus || is_digit)

   // A run never ends on its minus sign.
   `SIDA_ASSERT_SAME(a_minus_not_last, clock, reset, rsp_strobe && is_minus, !rsp_last)

   // A minus sign is followed at once by a non-zero leading digit.
   `SIDA_ASSERT_NEXT(a_minus_then_digit, clock, reset, rsp_strobe && is_minus,
      rsp_strobe && !is_minus && !is_zero)

   // The characters of one run leave in consecutive cycles.
   `SIDA_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
